// ===== rtl/pcca_pkg.sv =====
// Package: types, constants and command/status structs for the shape area block.
`default_nettype none

package pcca_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int CNT_W = $clog2(MAX_VERTICES + 2);

	localparam int AREA_W = 41;
	localparam int SUM_W = 42;
	localparam int PROD_W = 34;
	localparam int SQRT_W = 36;
	localparam int SQRT_STEPS = SQRT_W / 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
	localparam int ROOT_W = 17;
	localparam int CIRC_W = 50;

	localparam logic [17:0] PI_Q16 = 18'd205887;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [AREA_W-1:0] shape_area;
		logic too_many_vertices;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VERTEX,
		ST_ACCUM,
		ST_CLOSE_MUL,
		ST_CLOSE_ACC,
		ST_SQUARE,
		ST_PI,
		ST_SQRT,
		ST_CAP,
		ST_AREA,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_EDGE,
		MUL_CLOSE,
		MUL_SQUARE
	} mul_sel_t;

	typedef struct packed {
		logic capture;
		logic vertex_en;
		logic mul_en;
		mul_sel_t mul_sel;
		logic acc_en;
		logic rr_en;
		logic pi_en;
		logic sqrt_step;
		logic cap_en;
		logic area_en;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic over;
		logic one;
		logic two;
		logic last;
		logic sqrt_last;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/pcca_datapath.sv =====
// Datapath: vertex registers, cross-product accumulator, circle, square root and result.
`default_nettype none

module pcca_datapath
	import pcca_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire vertex_t in_data,
	input  wire logic    cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire cmd_t    cmd,
	output status_t      status,
	output result_t      out_data
);

	vertex_t cur_q;
	logic signed [15:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [SUM_W-1:0] cross_sum_q;
	logic signed [PROD_W-1:0] p1_q, p2_q;
	logic [15:0] radius_q;
	logic [31:0] rr_q;
	logic [CIRC_W-1:0] circ_q;
	logic [SQRT_W-1:0] rem_q, root_q, bit_q;
	logic [SQRT_CNT_W-1:0] sq_cnt_q;
	logic [32:0] capm_q;
	logic [AREA_W-1:0] area_q;
	result_t out_q;

	logic signed [16:0] a1, b1, a2, b2;
	logic signed [16:0] dx, dy;
	logic signed [PROD_W:0] term;
	logic signed [SUM_W:0] sum_ext;
	logic signed [SUM_W-1:0] sum_sat;
	logic [SQRT_W-1:0] trial;
	logic [SUM_W-1:0] mag;
	logic [CIRC_W:0] circ_rnd;
	logic [AREA_W-1:0] area_next;

	always_comb begin
		status.over = cnt_q > CNT_W'(MAX_VERTICES);
		status.one = cnt_q == CNT_W'(1);
		status.two = cnt_q == CNT_W'(2);
		status.last = cur_q.last_vertex;
		status.sqrt_last = sq_cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1);
	end

	assign dx = 17'(cur_q.vertex_x) - 17'(first_x_q);
	assign dy = 17'(cur_q.vertex_y) - 17'(first_y_q);

	always_comb begin
		case (cmd.mul_sel)
			MUL_CLOSE: begin
				a1 = 17'(cur_q.vertex_x);
				b1 = 17'(first_y_q);
				a2 = 17'(first_x_q);
				b2 = 17'(cur_q.vertex_y);
			end
			MUL_SQUARE: begin
				a1 = dx;
				b1 = dx;
				a2 = dy;
				b2 = dy;
			end
			default: begin
				a1 = 17'(prev_x_q);
				b1 = 17'(cur_q.vertex_y);
				a2 = 17'(cur_q.vertex_x);
				b2 = 17'(prev_y_q);
			end
		endcase
	end

	assign term = (PROD_W + 1)'(p1_q) - (PROD_W + 1)'(p2_q);
	assign sum_ext = (SUM_W + 1)'(cross_sum_q) + (SUM_W + 1)'(term);

	always_comb begin
		if (!sum_ext[SUM_W] && sum_ext[SUM_W-1]) begin
			sum_sat = {1'b0, {(SUM_W - 1){1'b1}}};
		end else if (sum_ext[SUM_W] && !sum_ext[SUM_W-1]) begin
			sum_sat = {1'b1, {(SUM_W - 1){1'b0}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	assign trial = root_q + bit_q;
	assign mag = cross_sum_q[SUM_W-1] ? SUM_W'(-cross_sum_q) : SUM_W'(cross_sum_q);
	assign circ_rnd = (CIRC_W + 1)'(circ_q) + (CIRC_W + 1)'(17'h08000);

	always_comb begin
		if (status.over) begin
			area_next = AREA_MAX;
		end else if (status.one || status.two) begin
			area_next = AREA_W'(circ_rnd[CIRC_W:16])
				+ (status.two ? AREA_W'({capm_q, 1'b0}) : AREA_W'(0));
		end else begin
			area_next = mag[SUM_W-1:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			cnt_q <= '0;
			cross_sum_q <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			if (cmd.load_out) begin
				cnt_q <= '0;
				cross_sum_q <= '0;
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q <= '0;
				prev_y_q <= '0;
			end else begin
				if (cmd.capture && cnt_q <= CNT_W'(MAX_VERTICES)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmd.vertex_en && !status.over) begin
					if (status.one) begin
						first_x_q <= cur_q.vertex_x;
						first_y_q <= cur_q.vertex_y;
					end
					prev_x_q <= cur_q.vertex_x;
					prev_y_q <= cur_q.vertex_y;
				end
				if (cmd.acc_en) begin
					cross_sum_q <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q <= in_data;
		end
		if (cmd.mul_en) begin
			p1_q <= PROD_W'(a1) * PROD_W'(b1);
			p2_q <= PROD_W'(a2) * PROD_W'(b2);
		end
		if (cmd.rr_en) begin
			rr_q <= 32'(radius_q) * 32'(radius_q);
		end
		if (cmd.pi_en) begin
			circ_q <= CIRC_W'(rr_q) * CIRC_W'(PI_Q16);
			rem_q <= SQRT_W'(unsigned'(p1_q)) + SQRT_W'(unsigned'(p2_q));
			root_q <= '0;
			bit_q <= SQRT_W'(1) << (SQRT_W - 2);
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
			sq_cnt_q <= sq_cnt_q + SQRT_CNT_W'(1);
		end
		if (cmd.cap_en) begin
			capm_q <= 33'(radius_q) * 33'(root_q[ROOT_W-1:0]);
		end
		if (cmd.area_en) begin
			area_q <= area_next;
		end
		if (cmd.load_out) begin
			out_q.shape_area <= area_q;
			out_q.too_many_vertices <= status.over;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== rtl/pcca_ctrl.sv =====
// Controller: state machine sequencing vertex transfers, area steps and the result register.
`default_nettype none

module pcca_ctrl
	import pcca_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_next, finish_state;
	logic out_valid_q;
	logic load_ok;

	assign load_ok = !out_valid_q || out_ready;

	always_comb begin
		if (status.over) begin
			finish_state = ST_AREA;
		end else if (status.one || status.two) begin
			finish_state = ST_SQUARE;
		end else begin
			finish_state = ST_CLOSE_MUL;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_VERTEX;
				end
			end
			ST_VERTEX: begin
				if (!status.over && !status.one) begin
					state_next = ST_ACCUM;
				end else begin
					state_next = status.last ? finish_state : ST_IDLE;
				end
			end
			ST_ACCUM:     state_next = status.last ? finish_state : ST_IDLE;
			ST_CLOSE_MUL: state_next = ST_CLOSE_ACC;
			ST_CLOSE_ACC: state_next = ST_AREA;
			ST_SQUARE:    state_next = ST_PI;
			ST_PI:        state_next = status.two ? ST_SQRT : ST_AREA;
			ST_SQRT: begin
				if (status.sqrt_last) begin
					state_next = ST_CAP;
				end
			end
			ST_CAP:       state_next = ST_AREA;
			ST_AREA:      state_next = ST_DONE;
			ST_DONE: begin
				if (load_ok) begin
					state_next = ST_IDLE;
				end
			end
			default:      state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_EDGE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_VERTEX: begin
				cmd.vertex_en = 1'b1;
				cmd.mul_en = 1'b1;
			end
			ST_ACCUM:     cmd.acc_en = 1'b1;
			ST_CLOSE_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_CLOSE;
			end
			ST_CLOSE_ACC: cmd.acc_en = 1'b1;
			ST_SQUARE: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SQUARE;
				cmd.rr_en = 1'b1;
			end
			ST_PI:        cmd.pi_en = 1'b1;
			ST_SQRT:      cmd.sqrt_step = 1'b1;
			ST_CAP:       cmd.cap_en = 1'b1;
			ST_AREA:      cmd.area_en = 1'b1;
			ST_DONE:      cmd.load_out = load_ok;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/polygon_circle_capsule_area_top.sv =====
// Top level: shape area block joining the controller and the datapath.
//
// Vertices arrive on the in channel (valid/ready), one signed Q8.8 point per
// transfer, with last_vertex marking the final point of a shape. The area of
// each shape leaves on the out channel (valid/ready) as unsigned Q16.16 with
// a flag for shapes longer than MAX_VERTICES points (area then saturated).
// shape_radius is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// One point gives a circle, two a capsule, three or more a closed polygon.
// A vertex is captured and multiplied, then accumulated unless it is the
// first point of a shape or past MAX_VERTICES. A polygon then takes the
// close multiply and accumulate steps, a circle the square and pi steps, a
// capsule these and the 18-step bit-per-cycle square root and cap steps,
// each before the area step; a shape past MAX_VERTICES goes to it directly.
// A finished result waits in the output register; a new shape is taken while
// it waits, and the next result holds in the datapath until the receiver
// takes the one before it.
// Reset clears the radius, the shape state and the output valid.
`default_nettype none

module polygon_circle_capsule_area_top
	import pcca_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire vertex_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data,
	input  wire logic    cfg_we,
	input  wire logic [15:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	pcca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pcca_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
